// ----- hdl/fpa_pkg.sv -----
// shared types, opcodes and the divider step function for the fixed-point alu
package fpa_pkg;

    localparam int FRACTION_BITS = 8;
    localparam int DIV_W         = 32 + FRACTION_BITS;

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_INC = 4'd4;
    localparam logic [3:0] OP_DEC = 4'd5;
    localparam logic [3:0] OP_MIN = 4'd6;
    localparam logic [3:0] OP_MAX = 4'd7;
    localparam logic [3:0] OP_I2F = 4'd8;
    localparam logic [3:0] OP_F2I = 4'd9;

    // results that ride alongside the divider
    typedef struct packed {
        logic [31:0] res;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        dz;
        logic        is_div;
        logic        neg;
    } t_side;

    // restoring divider state: partial remainder, dividend/quotient, divisor
    typedef struct packed {
        logic [31:0]      rem;
        logic [DIV_W-1:0] dq;
        logic [31:0]      den;
    } t_div;

    typedef struct packed {
        t_side side;
        t_div  div;
    } t_pipe;

    // one quotient bit of a restoring division
    function automatic t_pipe fpa_step(t_pipe p);
        t_pipe       q;
        logic [32:0] part;
        logic [32:0] trial;
        q     = p;
        part  = {p.div.rem, p.div.dq[DIV_W-1]};
        trial = part - {1'b0, p.div.den};
        if (!trial[32]) begin
            q.div.rem = trial[31:0];
        end else begin
            q.div.rem = part[31:0];
        end
        q.div.dq = {p.div.dq[DIV_W-2:0], ~trial[32]};
        return q;
    endfunction

endpackage

// ----- hdl/fpa_div_pipe.sv -----
// pipelined restoring divider, one quotient bit per stage, elastic stalls
module fpa_div_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  fpa_pkg::t_pipe i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output fpa_pkg::t_pipe o_data
);
    import fpa_pkg::*;

    logic  r_v   [DIV_W];
    t_pipe r_st  [DIV_W];
    logic  w_rdy [DIV_W+1];
    logic  w_src_v [DIV_W];
    t_pipe n_st  [DIV_W];

    // per-stage ready: a stage takes data when empty or when it moves on
    always_comb begin
        w_rdy[DIV_W] = i_ready;
        for (int k = DIV_W - 1; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    // next payload of every stage
    always_comb begin
        for (int k = 0; k < DIV_W; k++) begin
            if (k == 0) begin
                w_src_v[k] = i_valid;
                n_st[k]    = fpa_step(i_data);
            end else begin
                w_src_v[k] = r_v[k-1];
                n_st[k]    = fpa_step(r_st[k-1]);
            end
        end
    end

    // stage registers
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_W; k++) begin
            if (w_rdy[k]) begin
                r_v[k]  <= w_src_v[k] && i_rst_n;
                r_st[k] <= n_st[k];
            end else if (!i_rst_n) begin
                r_v[k]  <= 1'b0;
            end
        end
    end

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[DIV_W-1];
    assign o_data  = r_st[DIV_W-1];

endmodule

// ----- hdl/fixed_point_alu.sv -----
// signed 32-bit fixed-point alu, fully pipelined
// path from input transaction to result: input register, compute register, divider stages, output register
// throughput: one transaction per cycle unless the receiver stalls; the bit-per-stage divider sets the depth
// stalls collapse bubbles stage by stage; nothing is lost or repeated
// reset (synchronous, active low) empties every stage; no other state exists
module fixed_point_alu (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [3:0]  i_action,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_ready,
    output logic signed [31:0] o_result_value,
    output logic        o_a_greater,
    output logic        o_a_less,
    output logic        o_a_equal,
    output logic        o_divide_by_zero
);
    import fpa_pkg::*;

    logic               r0_v;
    logic [3:0]         r0_op;
    logic signed [31:0] r0_a;
    logic signed [31:0] r0_b;

    logic               r1_v;
    t_pipe              r1_p;
    logic signed [63:0] r1_prod;
    logic               r1_mul;

    logic               r2_v;
    t_side              r2_p;
    t_side              n2_p;

    logic  w_rdy0, w_rdy1, w_div_rdy, w_rdy_out, w_div_v;
    t_pipe n1_p, w_div_in, w_div_out;
    logic [31:0] w_abs_a, w_abs_b, w_q;

    assign w_rdy_out = !r2_v || i_ready;
    assign w_rdy1    = !r1_v || w_div_rdy;
    assign w_rdy0    = !r0_v || w_rdy1;
    assign o_ready   = w_rdy0;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_rdy0) begin
            r0_v <= i_valid;
        end
        if (w_rdy0) begin
            r0_op <= i_action;
            r0_a  <= i_operand_a;
            r0_b  <= i_operand_b;
        end
    end

    // decode, compare flags, simple results and divider setup
    always_comb begin
        w_abs_a = r0_a[31] ? 32'd0 - r0_a : r0_a;
        w_abs_b = r0_b[31] ? 32'd0 - r0_b : r0_b;
        n1_p = '0;
        n1_p.side.gt = r0_a > r0_b;
        n1_p.side.lt = r0_a < r0_b;
        n1_p.side.eq = r0_a == r0_b;
        n1_p.side.is_div = (r0_op == OP_DIV) && (r0_b != 32'sd0);
        n1_p.side.dz     = (r0_op == OP_DIV) && (r0_b == 32'sd0);
        n1_p.side.neg    = r0_a[31] ^ r0_b[31];
        n1_p.div.rem = '0;
        n1_p.div.dq  = {{(DIV_W-32){1'b0}}, w_abs_a} << FRACTION_BITS;
        n1_p.div.den = w_abs_b;
        case (r0_op)
            OP_ADD:  n1_p.side.res = r0_a + r0_b;
            OP_SUB:  n1_p.side.res = r0_a - r0_b;
            OP_INC:  n1_p.side.res = r0_a + 32'sd1;
            OP_DEC:  n1_p.side.res = r0_a - 32'sd1;
            OP_MIN:  n1_p.side.res = (r0_a < r0_b) ? r0_a : r0_b;
            OP_MAX:  n1_p.side.res = (r0_a > r0_b) ? r0_a : r0_b;
            OP_I2F:  n1_p.side.res = r0_a << FRACTION_BITS;
            OP_F2I:  n1_p.side.res = r0_a >>> FRACTION_BITS;
            default: n1_p.side.res = '0;
        endcase
    end

    // compute register with the product
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_rdy1) begin
            r1_v <= r0_v;
        end
        if (w_rdy1) begin
            r1_p    <= n1_p;
            r1_prod <= 64'(r0_a) * 64'(r0_b);
            r1_mul  <= r0_op == OP_MUL;
        end
    end

    // fold the scaled product into the carried result
    always_comb begin
        w_div_in = r1_p;
        if (r1_mul) begin
            w_div_in.side.res = r1_prod[FRACTION_BITS+31:FRACTION_BITS];
        end
    end

    fpa_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r1_v),
        .o_ready (w_div_rdy),
        .i_data  (w_div_in),
        .o_valid (w_div_v),
        .i_ready (w_rdy_out),
        .o_data  (w_div_out)
    );

    // quotient sign fix
    assign w_q = w_div_out.div.dq[31:0];
    always_comb begin
        n2_p = w_div_out.side;
        if (w_div_out.side.is_div) begin
            n2_p.res = w_div_out.side.neg ? 32'd0 - w_q : w_q;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_rdy_out) begin
            r2_v <= w_div_v;
        end
        if (w_rdy_out) begin
            r2_p <= n2_p;
        end
    end

    assign o_valid          = r2_v;
    assign o_result_value   = r2_p.res;
    assign o_a_greater      = r2_p.gt;
    assign o_a_less         = r2_p.lt;
    assign o_a_equal        = r2_p.eq;
    assign o_divide_by_zero = r2_p.dz;

endmodule

// ----- hdl/fpa_checker.sv -----
// port-level checks for the fixed-point alu, bound to the top level
module fpa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_ready,
    input logic [31:0] o_result_value,
    input logic        o_a_greater,
    input logic        o_a_less,
    input logic        o_a_equal,
    input logic        o_divide_by_zero
);
    // pipeline is empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // exactly one compare flag per result
    a_flags_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $onehot({o_a_greater, o_a_less, o_a_equal}))
        else $error("compare flags not one-hot");

    // divide by zero returns zero
    a_dz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_divide_by_zero) |-> (o_result_value == 32'd0))
        else $error("divide by zero with nonzero result");

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_result_value)))
        else $error("stalled result changed");
endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);

// ----- tb/fixed_point_alu_checker.sv -----
// result predictor and comparator for the fixed-point alu testbench
module fixed_point_alu_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic [3:0]         i_action,
    input  logic signed [31:0] i_operand_a,
    input  logic signed [31:0] i_operand_b,
    input  logic               i_valid_out,
    input  logic               i_ready,
    input  logic signed [31:0] i_result_value,
    input  logic               i_a_greater,
    input  logic               i_a_less,
    input  logic               i_a_equal,
    input  logic               i_divide_by_zero,
    output int                 o_fail_count,
    output int                 o_pending
);
    import fpa_pkg::*;

    typedef struct packed {
        logic [31:0] value;
        logic        gt;
        logic        lt;
        logic        eq;
        logic        dz;
    } t_alu_result;

    t_alu_result expected_results[$];

    // compute the expected alu result for one input transaction
    function automatic t_alu_result alu_predict(logic [3:0] op, logic signed [31:0] a,
                                                logic signed [31:0] b);
        t_alu_result r;
        logic signed [63:0] wide;
        r = '0;
        r.gt = a > b;
        r.lt = a < b;
        r.eq = a == b;
        case (op)
            OP_ADD: r.value = a + b;
            OP_SUB: r.value = a - b;
            OP_MUL: begin
                wide = 64'(a) * 64'(b);
                wide = wide >>> FRACTION_BITS;
                r.value = wide[31:0];
            end
            OP_DIV: begin
                if (b == 0) begin
                    r.dz = 1'b1;
                end else begin
                    wide = 64'(a) <<< FRACTION_BITS;
                    wide = wide / 64'(b);
                    r.value = wide[31:0];
                end
            end
            OP_INC: r.value = a + 32'sd1;
            OP_DEC: r.value = a - 32'sd1;
            OP_MIN: r.value = (a < b) ? a : b;
            OP_MAX: r.value = (a > b) ? a : b;
            OP_I2F: r.value = a <<< FRACTION_BITS;
            OP_F2I: r.value = a >>> FRACTION_BITS;
            default: r.value = '0;
        endcase
        return r;
    endfunction

    assign o_pending = expected_results.size();

    // predict on accepted inputs, compare on accepted outputs
    always @(posedge i_clk) begin
        t_alu_result exp_r;
        int          errs;
        errs = 0;
        if (!i_rst_n) begin
            o_fail_count <= 0;
        end
        if (i_rst_n && i_valid && i_ready_in) begin
            expected_results.push_back(alu_predict(i_action, i_operand_a, i_operand_b));
        end
        if (i_rst_n && i_valid_out && i_ready) begin
            if (expected_results.size() == 0) begin
                $error("result transaction with none expected");
                errs = errs + 1;
            end else begin
                exp_r = expected_results.pop_front();
                if (exp_r.value !== i_result_value) begin
                    $error("result_value expected %0d actual %0d", $signed(exp_r.value),
                           i_result_value);
                    errs = errs + 1;
                end
                if (exp_r.gt !== i_a_greater) begin
                    $error("a_greater expected %0b actual %0b", exp_r.gt, i_a_greater);
                    errs = errs + 1;
                end
                if (exp_r.lt !== i_a_less) begin
                    $error("a_less expected %0b actual %0b", exp_r.lt, i_a_less);
                    errs = errs + 1;
                end
                if (exp_r.eq !== i_a_equal) begin
                    $error("a_equal expected %0b actual %0b", exp_r.eq, i_a_equal);
                    errs = errs + 1;
                end
                if (exp_r.dz !== i_divide_by_zero) begin
                    $error("divide_by_zero expected %0b actual %0b", exp_r.dz,
                           i_divide_by_zero);
                    errs = errs + 1;
                end
            end
        end
        if (errs != 0) begin
            o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

// ----- tb/fixed_point_alu_tb.sv -----
// stimulus and verdict for the fixed-point alu testbench
module fixed_point_alu_tb;
    import fpa_pkg::*;

    localparam int LATENCY = FRACTION_BITS + 35;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [3:0]         i_action = OP_ADD;
    logic signed [31:0] i_operand_a = '0;
    logic signed [31:0] i_operand_b = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic signed [31:0] o_result_value;
    logic               o_a_greater;
    logic               o_a_less;
    logic               o_a_equal;
    logic               o_divide_by_zero;
    int                 fail_count;
    int                 pending;
    int                 send_idle_pct = 19;
    int                 recv_idle_pct = 54;

    fixed_point_alu dut (.*);

    fixed_point_alu_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_ready_in(o_ready),
        .i_action(i_action), .i_operand_a(i_operand_a), .i_operand_b(i_operand_b),
        .i_valid_out(o_valid), .i_ready(i_ready), .i_result_value(o_result_value),
        .i_a_greater(o_a_greater), .i_a_less(o_a_less), .i_a_equal(o_a_equal),
        .i_divide_by_zero(o_divide_by_zero), .o_fail_count(fail_count),
        .o_pending(pending)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // receiver stalls at random
    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // timeout guard
    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // send one transaction, with random idle cycles before it
    task automatic send_op(logic [3:0] op, logic [31:0] a, logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_action    <= op;
        i_operand_a <= a;
        i_operand_b <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // random operand biased toward corner values
    function automatic logic [31:0] pick_operand();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'(int'($urandom_range(8)) - 4);
            3: return 32'(int'($urandom_range(2048)) - 1024);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] a;
        logic [3:0]  op;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: every opcode at the extremes, divide by zero, unused opcodes
        for (int k = 0; k <= 9; k++) begin
            send_op(4'(k), 32'h7fff_ffff, 32'h8000_0000);
        end
        send_op(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_op(OP_MUL, 32'hffff_ff00, 32'h0000_0080);
        send_op(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_op(OP_DIV, 32'h0000_0300, 32'h0000_0000);
        send_op(OP_DIV, 32'hffff_fd00, 32'h0000_0200);
        send_op(OP_INC, 32'h7fff_ffff, 32'h7fff_ffff);
        send_op(OP_DEC, 32'h8000_0000, 32'h0);
        send_op(OP_MIN, 32'h5, 32'h5);
        send_op(OP_F2I, 32'hffff_ffff, 32'h1);
        send_op(4'd10, 32'h1, 32'h2);
        send_op(4'd15, 32'hffff_ffff, 32'h0);

        // random: three idle profiles
        for (int phase = 0; phase < 3; phase++) begin
            if (phase == 1) begin
                send_idle_pct = 54;
                recv_idle_pct = 19;
            end else if (phase == 2) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            for (int n = 0; n < 480; n++) begin
                op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                               : 4'($urandom_range(9));
                a = pick_operand();
                if ($urandom_range(7) == 0) begin
                    send_op(op, a, a);
                end else if (op == OP_DIV && $urandom_range(9) == 0) begin
                    send_op(op, a, 32'h0);
                end else begin
                    send_op(op, a, pick_operand());
                end
            end
        end
        i_valid <= 1'b0;

        // drain
        while (pending != 0) @(negedge i_clk);
        repeat (LATENCY + 10) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
